// ===== design/qfgt_pkg.sv =====
// Package for the quoted field grid tokenizer: beat structs, scan modes,
// character codes and the width limits of the counters.
// Depends on nothing; the tokenizer module imports it.
package qfgt_pkg;

  localparam int unsigned WidthBits = 8;
  localparam int unsigned RowBits   = 16;

  localparam logic [WidthBits-1:0] WidthMax = '1;
  localparam logic [RowBits-1:0]   RowsMax  = '1;

  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef enum logic [2:0] {
    MODE_BETWEEN    = 3'd0,
    MODE_QUOTED     = 3'd1,
    MODE_RAW        = 3'd2,
    MODE_LINE_START = 3'd3,
    MODE_COMMENT    = 3'd4
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic                 char_valid;
    logic [7:0]           char_out;
    logic                 cell_begin;
    logic                 cell_end;
    logic                 row_end;
    logic [WidthBits-1:0] row_width;
    logic [RowBits-1:0]   row_total;
    logic [WidthBits-1:0] widest_row;
  } out_beat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c inside {ChSpace, ChTab});
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c inside {ChCr, ChLf});
  endfunction

endpackage

// ===== design/quoted_field_grid_tokenizer.sv =====
// Top level of the quoted field grid tokenizer: scanner state, counters,
// output register and skid stage. Depends on qfgt_pkg.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------
//   in      | sink      | in_valid_i / in_stall_o   | in_data_i  (in_beat_t)
//   out     | source    | out_valid_o / out_stall_i | out_data_o (out_beat_t)
//
// Every accepted byte gives exactly one registered result beat, and a new
// byte can be taken in every cycle while the skid stage is empty. The
// scanner state and counters update in the cycle of acceptance, so the only
// loop is the mode and counter update. Reset puts the scanner at line start
// with all counters cleared and both output stages empty. When the sink
// stalls, one result waits in the output register and one more in the skid
// stage; only a full skid stage stalls the input.
module quoted_field_grid_tokenizer
  import qfgt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  // Scanner state.
  scan_mode_e           mode_q, mode_d;
  logic                 esc_q, esc_d;
  logic                 has_cell_q, has_cell_d;
  logic [WidthBits-1:0] cells_q, cells_d;
  logic [RowBits-1:0]   rows_q, rows_d;
  logic [WidthBits-1:0] maxw_q, maxw_d;

  // Output register and skid stage.
  logic      out_valid_q, skid_valid_q;
  out_beat_t out_q, skid_q;

  logic      in_fire, out_fire;
  out_beat_t res;

  // Per-byte decisions.
  logic       eoi;
  logic [7:0] c;
  logic       open_cell, close_row, emit, cell_end;
  logic [7:0] emit_char;

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign eoi = in_data_i.end_of_input;
  assign c   = eoi ? ChLf : in_data_i.in_byte;

  // Mode decoding. Between cells and line start behave the same way.
  always_comb begin
    open_cell = 1'b0;
    close_row = 1'b0;
    emit      = 1'b0;
    emit_char = c;
    cell_end  = 1'b0;
    mode_d    = mode_q;
    esc_d     = esc_q;
    case (mode_q)
      MODE_QUOTED: begin
        if (eoi) begin
          // An unterminated quote is closed at end of input.
          cell_end  = 1'b1;
          esc_d     = 1'b0;
          close_row = 1'b1;
        end else if (esc_q) begin
          esc_d = 1'b0;
          if (c == ChQuote || c == ChBslash) begin
            emit = 1'b1;
          end else if (c == ChT) begin
            emit      = 1'b1;
            emit_char = ChTab;
          end else if (c == ChN) begin
            emit      = 1'b1;
            emit_char = ChLf;
          end
        end else if (c == ChBslash) begin
          esc_d = 1'b1;
        end else if (c == ChQuote) begin
          cell_end = 1'b1;
          mode_d   = MODE_BETWEEN;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_RAW: begin
        if (is_blank(c)) begin
          cell_end = 1'b1;
          mode_d   = MODE_BETWEEN;
        end else if (is_break(c)) begin
          cell_end  = 1'b1;
          close_row = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_COMMENT: begin
        close_row = is_break(c);
      end
      default: begin
        if (is_break(c)) begin
          close_row = 1'b1;
        end else if (c == ChHash) begin
          mode_d = MODE_COMMENT;
        end else if (c == ChQuote) begin
          open_cell = 1'b1;
          esc_d     = 1'b0;
          mode_d    = MODE_QUOTED;
        end else if (!is_blank(c)) begin
          open_cell = 1'b1;
          emit      = 1'b1;
          mode_d    = MODE_RAW;
        end else begin
          mode_d = MODE_BETWEEN;
        end
      end
    endcase
    if (close_row) begin
      mode_d = MODE_LINE_START;
    end
  end

  // Counters. A row is only counted if it holds at least one cell.
  always_comb begin
    has_cell_d = has_cell_q;
    cells_d    = cells_q;
    rows_d     = rows_q;
    maxw_d     = maxw_q;
    if (close_row) begin
      has_cell_d = 1'b0;
      cells_d    = '0;
      if (has_cell_q) begin
        if (rows_q != RowsMax) begin
          rows_d = rows_q + 1'b1;
        end
        if (cells_q > maxw_q) begin
          maxw_d = cells_q;
        end
      end
    end else if (open_cell) begin
      has_cell_d = 1'b1;
      if (cells_q != WidthMax) begin
        cells_d = cells_q + 1'b1;
      end
    end
  end

  always_comb begin
    res.char_valid = emit;
    res.char_out   = emit ? emit_char : 8'h00;
    res.cell_begin = open_cell;
    res.cell_end   = cell_end;
    res.row_end    = close_row && has_cell_q;
    res.row_width  = (close_row && has_cell_q) ? cells_q : '0;
    res.row_total  = rows_d;
    res.widest_row = maxw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_LINE_START;
      esc_q      <= 1'b0;
      has_cell_q <= 1'b0;
      cells_q    <= '0;
      rows_q     <= '0;
      maxw_q     <= '0;
    end else if (in_fire) begin
      mode_q     <= mode_d;
      esc_q      <= esc_d;
      has_cell_q <= has_cell_d;
      cells_q    <= cells_d;
      rows_q     <= rows_d;
      maxw_q     <= maxw_d;
    end
  end

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // The skid stage only fills behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while the output register is empty");

  // An escape can only be pending inside a quoted cell.
  a_esc_in_quote : assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (mode_q == MODE_QUOTED))
    else $error("escape pending outside a quoted cell");

  // An open cell always marks its row as holding a cell.
  a_cell_marks_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RAW || mode_q == MODE_QUOTED) |-> has_cell_q)
    else $error("open cell in a row not marked as holding a cell");

  // A finished row always reports a nonzero width.
  a_row_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.row_end) |-> (out_q.row_width != '0))
    else $error("row end with zero width");

  // A cell never opens and closes on the same byte.
  a_begin_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.cell_begin) |-> !out_q.cell_end)
    else $error("cell begins and ends on one byte");

endmodule
